### rtl/core/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg: shared types and constants of the pad edge and auto-repeat unit
// Position layout, hat decoding, register indexes and the frame, result and
// configuration types used by the channels and the core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pae_pkg;

  // Position layout of the merged 20-bit mask
  localparam int PosCount   = 20;
  localparam int ButtonBase = 4;
  localparam int NumButtons = 16;

  localparam logic [3:0] PosUp    = 4'b0001;
  localparam logic [3:0] PosDown  = 4'b0010;
  localparam logic [3:0] PosLeft  = 4'b0100;
  localparam logic [3:0] PosRight = 4'b1000;

  // Per-position counter widths
  localparam int CountW = 9;
  localparam int PhaseW = 8;

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegRepeatDelay    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegRepeatInterval = 8'd1;
  localparam logic [CfgIdxW-1:0] RegUseAlias       = 8'd2;
  localparam logic [CfgIdxW-1:0] RegUseHat         = 8'd3;
  localparam int CfgDataW = 8;

  // Register reset values
  localparam logic [7:0] RepeatDelayReset    = 8'd30;
  localparam logic [7:0] RepeatIntervalReset = 8'd3;
  localparam logic       UseAliasReset       = 1'b1;
  localparam logic       UseHatReset         = 1'b0;

  // Hat direction codes
  typedef enum logic [3:0] {
    HatCenter = 4'd0,
    HatN      = 4'd1,
    HatNE     = 4'd2,
    HatE      = 4'd3,
    HatSE     = 4'd4,
    HatS      = 4'd5,
    HatSW     = 4'd6,
    HatW      = 4'd7,
    HatNW     = 4'd8
  } hat_dir_e;

  typedef struct packed {
    logic [7:0] repeat_delay;
    logic [7:0] repeat_interval;
    logic       use_alias;
    logic       use_hat;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0]   axis_x;
    logic signed [15:0]   axis_y;
    logic [3:0]           hat_dir;
    logic [NumButtons-1:0] buttons;
    logic [PosCount-1:0]  alias_keys;
  } frame_t;

  typedef struct packed {
    logic [PosCount-1:0] pressed;
    logic [PosCount-1:0] released;
    logic [PosCount-1:0] held;
    logic [PosCount-1:0] repeat_res;
  } result_t;

  // Map a hat code onto direction bits; codes past NW add nothing
  function automatic logic [3:0] hat_dirs(logic [3:0] code);
    logic [3:0] dirs;
    unique case (code)
      HatN:    dirs = PosUp;
      HatNE:   dirs = PosUp | PosRight;
      HatE:    dirs = PosRight;
      HatSE:   dirs = PosDown | PosRight;
      HatS:    dirs = PosDown;
      HatSW:   dirs = PosDown | PosLeft;
      HatW:    dirs = PosLeft;
      HatNW:   dirs = PosUp | PosLeft;
      default: dirs = 4'b0000;
    endcase
    return dirs;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pae_if.sv
// ----------------------------------------------------------------------------
// pae_if: request channels of the pad edge and auto-repeat unit
// Frame, result and configuration write channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pae_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic [3:0]         hat_dir;
  logic [15:0]        buttons;
  logic [19:0]        alias_keys;

  modport source (output valid, axis_x, axis_y, hat_dir, buttons, alias_keys,
                  input ready);
  modport sink   (input valid, axis_x, axis_y, hat_dir, buttons, alias_keys,
                  output ready);
endinterface

interface pae_result_if;
  logic        valid;
  logic        ready;
  logic [19:0] pressed;
  logic [19:0] released;
  logic [19:0] held;
  logic [19:0] repeat_res;

  modport source (output valid, pressed, released, held, repeat_res,
                  input ready);
  modport sink   (input valid, pressed, released, held, repeat_res,
                  output ready);
endinterface

interface pae_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/pad_edge_and_auto_repeat_unit.sv
// ----------------------------------------------------------------------------
// pad_edge_and_auto_repeat_unit: pad edge detector with typematic repeat
// Top level: frame register, merge and per-position repeat cells, result
// register.
// ----------------------------------------------------------------------------
// Each polling frame is taken into a frame register, merged into a position
// mask and compared with the previous frame in a single pass, and the
// pressed, released, held and repeat masks land in the result register. The
// unit takes one frame every cycle while the result channel does not stall;
// a frame passes through the frame register and then the result register,
// which enclose the per-position logic, and a stalled result channel holds
// it in the frame register. When the result channel stalls, the frame
// register still takes one more frame before the input stops.
// Configuration writes take effect at once and belong in idle periods.
`default_nettype none

module pad_edge_and_auto_repeat_unit #(
  parameter int NumPositions = 20
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pae_cfg_if.sink      cfg_i,
  pae_frame_if.sink    in_i,
  pae_result_if.source out_o
);
  import pae_pkg::*;

  cfg_t                    cfg;
  frame_t                  frame_q;
  logic                    frame_valid_q;
  logic                    advance;
  logic [PosCount-1:0]     merged;
  logic [NumPositions-1:0] cur;
  logic [NumPositions-1:0] prev_q;
  logic [NumPositions-1:0] held;
  logic [NumPositions-1:0] rep;
  result_t                 res_d, res_q;
  logic                    res_valid_q;

  pae_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Move the frame on when the result register is free or being drained
  assign advance    = frame_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !frame_valid_q || advance;

  // Frame register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      frame_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      frame_q.axis_x     <= in_i.axis_x;
      frame_q.axis_y     <= in_i.axis_y;
      frame_q.hat_dir    <= in_i.hat_dir;
      frame_q.buttons    <= in_i.buttons;
      frame_q.alias_keys <= in_i.alias_keys;
    end
  end

  pae_merge u_merge (
    .frame_i (frame_q),
    .cfg_i   (cfg),
    .mask_o  (merged)
  );

  // Fit the merged mask to the position count; extra positions stay low
  for (genvar j = 0; j < NumPositions; j++) begin : g_pos
    if (j < PosCount) begin : g_src
      assign cur[j] = merged[j];
    end else begin : g_nosrc
      assign cur[j] = 1'b0;
    end

    pae_rep_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .held_i    (held[j]),
      .cfg_i     (cfg),
      .repeat_o  (rep[j])
    );
  end

  assign held = prev_q & cur;

  // Previous mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (advance) begin
      prev_q <= cur;
    end
  end

  // Show only the first twenty positions
  for (genvar k = 0; k < PosCount; k++) begin : g_out
    if (k < NumPositions) begin : g_live
      assign res_d.pressed[k]    = ~prev_q[k] & cur[k];
      assign res_d.released[k]   = prev_q[k] & ~cur[k];
      assign res_d.held[k]       = held[k];
      assign res_d.repeat_res[k] = rep[k];
    end else begin : g_dead
      assign res_d.pressed[k]    = 1'b0;
      assign res_d.released[k]   = 1'b0;
      assign res_d.held[k]       = 1'b0;
      assign res_d.repeat_res[k] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.pressed    = res_q.pressed;
  assign out_o.released   = res_q.released;
  assign out_o.held       = res_q.held;
  assign out_o.repeat_res = res_q.repeat_res;

`ifndef SYNTHESIS
  // A position cannot be pressed and released in one frame
  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.pressed & res_q.released) == '0))
    else $error("pressed and released overlap");

  // Repeat pulses only on held positions
  a_repeat_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.repeat_res & ~res_q.held) == '0))
    else $error("repeat pulse on a position that is not held");

  // A frame waiting behind a stalled result stays in the frame register
  a_frame_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_q && !advance) |=> (frame_valid_q && $stable(frame_q)))
    else $error("waiting frame lost");

  // A frame that moves on always leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("result missing after frame advance");
`endif

endmodule

`default_nettype wire

### rtl/core/pae_cfg_regs.sv
// ----------------------------------------------------------------------------
// pae_cfg_regs: configuration registers
// Holds repeat delay, repeat interval and the alias and hat enables.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_cfg_regs (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pae_cfg_if.sink     cfg_i,
  output pae_pkg::cfg_t cfg_o
);
  import pae_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always take write requests
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes drop the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegRepeatDelay:    cfg_d.repeat_delay    = cfg_i.data;
        RegRepeatInterval: cfg_d.repeat_interval = cfg_i.data;
        RegUseAlias:       cfg_d.use_alias       = cfg_i.data[0];
        RegUseHat:         cfg_d.use_hat         = cfg_i.data[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_delay    <= RepeatDelayReset;
      cfg_q.repeat_interval <= RepeatIntervalReset;
      cfg_q.use_alias       <= UseAliasReset;
      cfg_q.use_hat         <= UseHatReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/pae_merge.sv
// ----------------------------------------------------------------------------
// pae_merge: frame to position mask
// Folds stick signs, hat directions, buttons and alias keys into one mask.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_merge (
  input  pae_pkg::frame_t           frame_i,
  input  pae_pkg::cfg_t             cfg_i,
  output logic [pae_pkg::PosCount-1:0] mask_o
);
  import pae_pkg::*;

  logic [3:0] stick_dirs;
  logic [3:0] hat_bits;

  // Derive directions from the axis signs
  always_comb begin
    stick_dirs = 4'b0000;
    if (frame_i.axis_x[15]) begin
      stick_dirs = stick_dirs | PosLeft;
    end else if (frame_i.axis_x != 16'sd0) begin
      stick_dirs = stick_dirs | PosRight;
    end
    if (frame_i.axis_y[15]) begin
      stick_dirs = stick_dirs | PosUp;
    end else if (frame_i.axis_y != 16'sd0) begin
      stick_dirs = stick_dirs | PosDown;
    end
  end

  assign hat_bits = cfg_i.use_hat ? hat_dirs(frame_i.hat_dir) : 4'b0000;

  // Combine all sources
  assign mask_o = {frame_i.buttons, stick_dirs | hat_bits}
                | (cfg_i.use_alias ? frame_i.alias_keys : {PosCount{1'b0}});

endmodule

`default_nettype wire

### rtl/core/pae_rep_cell.sv
// ----------------------------------------------------------------------------
// pae_rep_cell: auto-repeat state of one position
// Keeps a saturating hold count and a repeat phase and flags repeat pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_rep_cell (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    advance_i,
  input  wire logic    held_i,
  input  pae_pkg::cfg_t cfg_i,
  output logic         repeat_o
);
  import pae_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW:0]   count_inc;
  logic [CountW:0]   count_sat;
  logic [PhaseW:0]   phase_inc;
  logic              past_delay;

  // Pulse on the first held frame, then once per interval past the delay
  assign past_delay = count_q > {1'b0, cfg_i.repeat_delay};
  assign repeat_o   = held_i &&
                      ((count_q == '0) || (past_delay && (phase_q == '0)));

  assign count_inc = {1'b0, count_q} + 1'b1;
  assign count_sat = {2'b00, cfg_i.repeat_delay} + 1'b1;
  assign phase_inc = {1'b0, phase_q} + 1'b1;

  // Advance or clear the counters
  always_comb begin
    if (held_i) begin
      count_d = (count_inc > count_sat) ? count_sat[CountW-1:0] : count_inc[CountW-1:0];
      phase_d = (phase_inc >= {1'b0, cfg_i.repeat_interval}) ? '0 : phase_inc[PhaseW-1:0];
    end else begin
      count_d = '0;
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

### dv/tb_pad_edge_and_auto_repeat_unit.sv
// ----------------------------------------------------------------------------
// tb_pad_edge_and_auto_repeat_unit: self-checking bench for the pad edge unit
// Sends polling frames over the frame channel, predicts the pressed, released,
// held and auto-repeat masks of every frame, and checks each result request
// in order. Register settings change between idle phases. Both channels stall
// at random.
// ----------------------------------------------------------------------------
module tb_pad_edge_and_auto_repeat_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pae_pkg::*;

  localparam int ReportLimit = 10;
  // Index outside the register map; the unit must ignore writes to it
  localparam logic [CfgIdxW-1:0] RegSpare = 8'hA5;

  typedef enum int {AxisZero, AxisPos, AxisNeg} axis_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pae_cfg_if    cfg_bus ();
  pae_frame_if  frame_bus ();
  pae_result_if result_bus ();

  pad_edge_and_auto_repeat_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (frame_bus),
    .out_o  (result_bus)
  );

  always #4 clk = ~clk;

  // Shadow registers and per-position state of the unit
  logic [7:0]          delay_reg;
  logic [7:0]          interval_reg;
  logic                alias_reg;
  logic                hat_reg;
  logic [PosCount-1:0] last_mask;
  logic [CountW-1:0]   held_frames [PosCount];
  logic [PhaseW-1:0]   pulse_phase [PosCount];

  frame_t  frames_to_send [$];
  result_t masks_due [$];
  frame_t  hold_frame;

  int src_idle_pct;
  int snk_idle_pct;
  int frames_sent;
  int results_seen;
  int repeat_pulses;
  int reg_writes;
  int mismatches;

  // Direction bits of a hat code; codes past NW add nothing
  function automatic logic [3:0] hat_to_dirs(logic [3:0] code);
    case (code)
      HatN:    return PosUp;
      HatNE:   return PosUp | PosRight;
      HatE:    return PosRight;
      HatSE:   return PosDown | PosRight;
      HatS:    return PosDown;
      HatSW:   return PosDown | PosLeft;
      HatW:    return PosLeft;
      HatNW:   return PosUp | PosLeft;
      default: return 4'b0000;
    endcase
  endfunction

  // Merge one frame, advance the hold counters and return the four masks
  function automatic result_t next_pad_masks(frame_t f);
    result_t             res;
    logic [PosCount-1:0] cur;
    logic [PosCount-1:0] both;
    logic [PosCount-1:0] pulses;
    logic [CountW-1:0]   cnt;
    logic [CountW-1:0]   ceiling;
    logic [PhaseW:0]     ph;
    cur = '0;
    pulses = '0;
    ceiling = {1'b0, delay_reg} + 1'b1;
    if (f.axis_x[15]) cur[3:0] |= PosLeft;
    else if (f.axis_x != 0) cur[3:0] |= PosRight;
    if (f.axis_y[15]) cur[3:0] |= PosUp;
    else if (f.axis_y != 0) cur[3:0] |= PosDown;
    cur[ButtonBase +: NumButtons] |= f.buttons;
    if (hat_reg) cur[3:0] |= hat_to_dirs(f.hat_dir);
    if (alias_reg) cur |= f.alias_keys;
    both = last_mask & cur;
    for (int p = 0; p < PosCount; p++) begin
      if (both[p]) begin
        cnt = held_frames[p];
        ph = {1'b0, pulse_phase[p]};
        // pulse on the first held frame, then on phase zero past the delay
        if (cnt == 0) pulses[p] = 1'b1;
        else if (cnt > delay_reg && ph == 0) pulses[p] = 1'b1;
        cnt = cnt + 1'b1;
        if (cnt > ceiling) cnt = ceiling;
        ph = ph + 1'b1;
        if (ph >= interval_reg) ph = '0;
        held_frames[p] = cnt;
        pulse_phase[p] = ph[PhaseW-1:0];
      end else begin
        held_frames[p] = '0;
        pulse_phase[p] = '0;
      end
    end
    res.pressed    = ~last_mask & cur;
    res.released   = last_mask & ~cur;
    res.held       = both;
    res.repeat_res = pulses;
    last_mask = cur;
    return res;
  endfunction

  function automatic frame_t mk_frame(logic [15:0] x, logic [15:0] y, logic [3:0] hat,
                                      logic [15:0] btn, logic [19:0] keys);
    frame_t f;
    f.axis_x     = x;
    f.axis_y     = y;
    f.hat_dir    = hat;
    f.buttons    = btn;
    f.alias_keys = keys;
    return f;
  endfunction

  function automatic logic [15:0] axis_value(axis_kind_e kind);
    logic [14:0] mag;
    mag = 15'($urandom);
    case (kind)
      AxisZero: return '0;
      AxisPos:  return (mag == 0) ? 16'h7FFF : {1'b0, mag};
      default:  return {1'b1, mag};
    endcase
  endfunction

  function automatic axis_kind_e kind_of(logic [15:0] a);
    if (a[15]) return AxisNeg;
    return (a == 0) ? AxisZero : AxisPos;
  endfunction

  // Drive frames: hold a stalled request, otherwise send the next one or idle
  always @(posedge clk) begin : frame_driver
    result_t res;
    if (!rst_n) begin
      frame_bus.valid <= 1'b0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        res = next_pad_masks(frames_to_send.pop_front());
        masks_due.push_back(res);
        repeat_pulses += $countones(res.repeat_res);
        frames_sent++;
      end
      if (frame_bus.valid && !frame_bus.ready) begin
        // hold the request until it is taken
      end else if (frames_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        frame_bus.valid      <= 1'b1;
        frame_bus.axis_x     <= frames_to_send[0].axis_x;
        frame_bus.axis_y     <= frames_to_send[0].axis_y;
        frame_bus.hat_dir    <= frames_to_send[0].hat_dir;
        frame_bus.buttons    <= frames_to_send[0].buttons;
        frame_bus.alias_keys <= frames_to_send[0].alias_keys;
      end else begin
        frame_bus.valid <= 1'b0;
      end
    end
  end

  // Take results and compare them with the oldest prediction
  always @(posedge clk) begin : result_monitor
    result_t want;
    result_t got;
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got.pressed    = result_bus.pressed;
        got.released   = result_bus.released;
        got.held       = result_bus.held;
        got.repeat_res = result_bus.repeat_res;
        results_seen++;
        if (masks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("[%0t] result with nothing expected: pressed %05h released %05h held %05h repeat %05h",
                     $realtime, got.pressed, got.released, got.held, got.repeat_res);
        end else begin
          want = masks_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("[%0t] result %0d mismatch", $realtime, results_seen);
              $display("  pressed  exp %05h got %05h", want.pressed, got.pressed);
              $display("  released exp %05h got %05h", want.released, got.released);
              $display("  held     exp %05h got %05h", want.held, got.held);
              $display("  repeat   exp %05h got %05h", want.repeat_res, got.repeat_res);
            end
          end
        end
      end
      result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      RegRepeatDelay:    delay_reg = val;
      RegRepeatInterval: interval_reg = val;
      RegUseAlias:       alias_reg = val[0];
      RegUseHat:         hat_reg = val[0];
      default:           ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [7:0] delay, input logic [7:0] interval,
                            input logic alias_on, input logic hat_on);
    write_reg(RegRepeatDelay, delay);
    write_reg(RegRepeatInterval, interval);
    // upper data bits are don't-care for the flag registers
    write_reg(RegUseAlias, {7'($urandom), alias_on});
    write_reg(RegUseHat, {7'($urandom), hat_on});
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until every frame is sent and every result has come, then settle
  task automatic wait_drained();
    while (frames_to_send.size() != 0 || masks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly held pad state with slow changes, plus the odd noise frame
  task automatic gen_frames(input int count, input int churn);
    frame_t noise;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < churn) hold_frame.buttons[$urandom_range(15)] ^= 1'b1;
      if ($urandom_range(99) < churn) hold_frame.alias_keys[$urandom_range(19)] ^= 1'b1;
      if ($urandom_range(99) < churn / 2)
        hold_frame.axis_x = axis_value(axis_kind_e'($urandom_range(2)));
      else if ($urandom_range(99) < 30)
        hold_frame.axis_x = axis_value(kind_of(hold_frame.axis_x));
      if ($urandom_range(99) < churn / 2)
        hold_frame.axis_y = axis_value(axis_kind_e'($urandom_range(2)));
      else if ($urandom_range(99) < 30)
        hold_frame.axis_y = axis_value(kind_of(hold_frame.axis_y));
      if ($urandom_range(99) < churn / 2) hold_frame.hat_dir = 4'($urandom_range(15));
      if ($urandom_range(99) < churn / 4) begin
        noise = mk_frame(16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
                         20'($urandom));
        frames_to_send.push_back(noise);
      end else begin
        frames_to_send.push_back(hold_frame);
      end
    end
  endtask

  initial begin : stimulus
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    frame_bus.valid      = 1'b0;
    frame_bus.axis_x     = '0;
    frame_bus.axis_y     = '0;
    frame_bus.hat_dir    = '0;
    frame_bus.buttons    = '0;
    frame_bus.alias_keys = '0;
    result_bus.ready     = 1'b0;
    delay_reg    = RepeatDelayReset;
    interval_reg = RepeatIntervalReset;
    alias_reg    = UseAliasReset;
    hat_reg      = UseHatReset;
    last_mask    = '0;
    for (int p = 0; p < PosCount; p++) begin
      held_frames[p] = '0;
      pulse_phase[p] = '0;
    end
    hold_frame = mk_frame('0, '0, HatCenter, '0, '0);
    frames_sent = 0;
    results_seen = 0;
    repeat_pulses = 0;
    reg_writes = 0;
    mismatches = 0;
    src_idle_pct = 34;
    snk_idle_pct = 83;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: stick extremes, all buttons, alias merge, hat ignored
    frames_to_send.push_back(mk_frame('0, '0, HatCenter, '0, '0));
    frames_to_send.push_back(mk_frame(16'h8000, 16'h7FFF, HatCenter, 16'hFFFF, '0));
    frames_to_send.push_back(mk_frame(16'h8000, 16'h7FFF, HatCenter, 16'hFFFF, '0));
    frames_to_send.push_back(mk_frame(16'h7FFF, 16'h8000, HatN, 16'hAAAA, 20'hFFFFF));
    frames_to_send.push_back(mk_frame(16'h0001, 16'hFFFF, HatNW, 16'h5555, '0));
    frames_to_send.push_back(mk_frame('0, '0, HatCenter, '0, 20'h0000F));
    frames_to_send.push_back(mk_frame('0, '0, HatCenter, '0, 20'hF0000));
    frames_to_send.push_back(mk_frame('0, '0, HatCenter, '0, '0));
    wait_drained();

    // No delay, every-frame repeat, hat on: sweep every hat code first
    set_config(8'd0, 8'd1, 1'b1, 1'b1);
    for (int h = 0; h < 16; h++) frames_to_send.push_back(mk_frame('0, '0, 4'(h), '0, '0));
    hold_frame = mk_frame(axis_value(AxisPos), axis_value(AxisNeg), HatSE, 16'($urandom),
                          20'($urandom));
    gen_frames(92, 12);
    wait_drained();
    gen_frames(92, 12);
    wait_drained();

    // Swap the stall pattern; interval zero, alias off
    src_idle_pct = 83;
    snk_idle_pct = 34;
    set_config(8'd5, 8'd0, 1'b0, 1'b1);
    gen_frames(100, 12);
    wait_drained();
    gen_frames(100, 12);
    wait_drained();

    // No stalls; longest delay and interval with long holds
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_frame.buttons = 16'($urandom) | 16'h0101;
    set_config(8'd255, 8'd255, 1'b1, 1'b0);
    gen_frames(150, 2);
    wait_drained();
    gen_frames(150, 2);
    wait_drained();

    // Shrink delay and interval while positions are still held
    write_reg(RegSpare, 8'($urandom));
    set_config(8'd3, 8'd7, 1'b1, 1'b1);
    gen_frames(75, 8);
    wait_drained();
    gen_frames(75, 8);
    wait_drained();

    repeat (8) @(posedge clk);
    mismatches += masks_due.size();
    $display("Sent %0d frames over %0d register writes, checked %0d results, %0d repeat pulses",
             frames_sent, reg_writes, results_seen, repeat_pulses);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin : watchdog
    #5ms;
    $display("Timeout after %0d frames and %0d results", frames_sent, results_seen);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
